/* hdl/tfc_pkg.sv */
package tfc_pkg;

   // Header field codes
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;

   // Result destination codes
   localparam logic [1:0] DEST_FLOW    = 2'd0;
   localparam logic [1:0] DEST_OTHER   = 2'd1;
   localparam logic [1:0] DEST_DISCARD = 2'd2;
   localparam logic [1:0] DEST_FULL    = 2'd3;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_ENABLE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_ADDRESS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OTHER_ENABLE   = 2'd2;

   localparam int unsigned FLOW_NUMBER_W = 6;

   // Connection key: one table entry
   typedef struct packed {
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] sport;
      logic [15:0] dport;
   } key_type;

   // Lookup token that walks the cell chain with a request
   typedef struct packed {
      logic act;     // a request occupies this slot
      logic found;   // matched or stored in an earlier cell
      logic fresh;   // the entry was created by this request
   } token_type;

endpackage

/* hdl/tfc_cell.sv */
module tfc_cell #(
   parameter int unsigned INDEX_W    = 6,
   parameter int unsigned COUNT_W    = 7,
   parameter int unsigned CELL_INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [COUNT_W-1:0]  flow_count,
   input  tfc_pkg::token_type  tok_in,
   input  tfc_pkg::key_type    key_in,
   input  logic [INDEX_W-1:0]  idx_in,
   output tfc_pkg::token_type  tok_out,
   output tfc_pkg::key_type    key_out,
   output logic [INDEX_W-1:0]  idx_out
);

   localparam logic [COUNT_W-1:0] MY_INDEX = COUNT_W'(CELL_INDEX);

   tfc_pkg::key_type   entry_ff;
   tfc_pkg::token_type tok_ff, tok_in_next;
   tfc_pkg::key_type   key_ff;
   logic [INDEX_W-1:0] idx_ff, idx_in_next;
   logic               entry_valid, fwd, rev, hit, store;

   // Entry is live once the count has passed this slot
   assign entry_valid = (MY_INDEX < flow_count);

   assign fwd = (entry_ff.src == key_in.src) && (entry_ff.dst == key_in.dst) &&
                (entry_ff.sport == key_in.sport) && (entry_ff.dport == key_in.dport);
   assign rev = (entry_ff.src == key_in.dst) && (entry_ff.dst == key_in.src) &&
                (entry_ff.sport == key_in.dport) && (entry_ff.dport == key_in.sport);

   assign hit   = tok_in.act && !tok_in.found && entry_valid && (fwd || rev);
   // first free slot takes a key that nobody matched
   assign store = tok_in.act && !tok_in.found && (flow_count == MY_INDEX);

   always_comb begin
      tok_in_next.act   = tok_in.act;
      tok_in_next.found = tok_in.found | hit | store;
      tok_in_next.fresh = tok_in.fresh | store;
      idx_in_next       = (hit || store) ? MY_INDEX[INDEX_W-1:0] : idx_in;
   end

   // Token control
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   // Payload hop and entry write
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      idx_ff <= idx_in_next;
      if (store) begin
         entry_ff <= key_in;
      end
   end

   assign tok_out = tok_ff;
   assign key_out = key_ff;
   assign idx_out = idx_ff;

endmodule

/* hdl/tcp_flow_table_classifier_core.sv */
// TCP flow table classifier.
// Request channel: present the header fields on the req_ ports with start
// high; the request is taken at a clock edge where start is high and busy
// is low. Result channel: rsp_strobe is high for one cycle with
// rsp_destination, rsp_flow_number and rsp_new_flow; the receiver cannot
// stall it, so it must take every result in that cycle.
// Non-flow packets (not IPv4/TCP, or filtered) answer in the cycle after
// the request and leave busy low, so one such request can be taken per
// cycle while no flow packet holds busy. A flow packet walks a chain of
// MAX_FLOWS cells, one cell per cycle, each holding one connection; the
// last cell's output passes through the result registers, and busy stays
// high until the result appears, so no new request is taken until then.
// CSR writes (csr_write_enable, csr_index, csr_write_data) take effect at
// the edge; write them only while idle. Reset clears the connection count
// and the registers; table contents are not cleared, stale entries beyond
// the count are never compared.
module tcp_flow_table_classifier_core #(
   parameter int unsigned MAX_FLOWS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [15:0]                        req_eth_type,
   input  logic [7:0]                         req_ip_protocol,
   input  logic [31:0]                        req_source_address,
   input  logic [31:0]                        req_dest_address,
   input  logic [15:0]                        req_src_port,
   input  logic [15:0]                        req_dst_port,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_destination,
   output logic [tfc_pkg::FLOW_NUMBER_W-1:0]  rsp_flow_number,
   output logic                               rsp_new_flow,
   input  logic                               csr_write_enable,
   input  logic [tfc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tfc_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int unsigned INDEX_W = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
   localparam int unsigned COUNT_W = $clog2(MAX_FLOWS + 1);

   logic        filter_enable_ff;
   logic [31:0] filter_address_ff;
   logic        other_enable_ff;
   logic        busy_ff, busy_in;
   logic [COUNT_W-1:0] flow_count_ff, flow_count_in;

   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]  rsp_dest_ff, rsp_dest_in;
   logic [tfc_pkg::FLOW_NUMBER_W-1:0] rsp_num_ff, rsp_num_in;
   logic        rsp_new_ff, rsp_new_in;

   logic accept, is_flow;

   tfc_pkg::token_type tok   [MAX_FLOWS+1];
   tfc_pkg::key_type   key   [MAX_FLOWS+1];
   logic [INDEX_W-1:0] idx   [MAX_FLOWS+1];
   tfc_pkg::token_type tail_tok;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_enable_ff  <= 1'b0;
         filter_address_ff <= '0;
         other_enable_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tfc_pkg::CSR_FILTER_ENABLE:  filter_enable_ff  <= csr_write_data[0];
            tfc_pkg::CSR_FILTER_ADDRESS: filter_address_ff <= csr_write_data;
            tfc_pkg::CSR_OTHER_ENABLE:   other_enable_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Classify the request header
   assign accept  = start && !busy_ff;
   assign is_flow = (req_eth_type == tfc_pkg::ETHERTYPE_IPV4) &&
                    (req_ip_protocol == tfc_pkg::PROTO_TCP) &&
                    (!filter_enable_ff || (req_source_address == filter_address_ff));

   // Chain head
   always_comb begin
      tok[0].act   = accept && is_flow;
      tok[0].found = 1'b0;
      tok[0].fresh = 1'b0;
      key[0].src   = req_source_address;
      key[0].dst   = req_dest_address;
      key[0].sport = req_src_port;
      key[0].dport = req_dst_port;
      idx[0]       = '0;
   end

   for (genvar g = 0; g < MAX_FLOWS; g++) begin : g_cell
      tfc_cell #(
         .INDEX_W    (INDEX_W),
         .COUNT_W    (COUNT_W),
         .CELL_INDEX (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .flow_count (flow_count_ff),
         .tok_in     (tok[g]),
         .key_in     (key[g]),
         .idx_in     (idx[g]),
         .tok_out    (tok[g+1]),
         .key_out    (key[g+1]),
         .idx_out    (idx[g+1])
      );
   end

   assign tail_tok = tok[MAX_FLOWS];

   // Result select, busy and count update
   always_comb begin
      busy_in       = busy_ff;
      flow_count_in = flow_count_ff;
      rsp_strobe_in = 1'b0;
      rsp_dest_in   = tfc_pkg::DEST_DISCARD;
      rsp_num_in    = '0;
      rsp_new_in    = 1'b0;
      priority if (tail_tok.act) begin
         busy_in       = 1'b0;
         rsp_strobe_in = 1'b1;
         if (tail_tok.found) begin
            rsp_dest_in = tfc_pkg::DEST_FLOW;
            rsp_num_in  = tfc_pkg::FLOW_NUMBER_W'(idx[MAX_FLOWS]);
            rsp_new_in  = tail_tok.fresh;
            if (tail_tok.fresh) begin
               flow_count_in = flow_count_ff + COUNT_W'(1);
            end
         end else begin
            rsp_dest_in = tfc_pkg::DEST_FULL;
         end
      end else if (accept && is_flow) begin
         busy_in = 1'b1;
      end else if (accept) begin
         rsp_strobe_in = 1'b1;
         rsp_dest_in   = other_enable_ff ? tfc_pkg::DEST_OTHER : tfc_pkg::DEST_DISCARD;
      end else begin
         busy_in = busy_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         flow_count_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         flow_count_ff <= flow_count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_dest_ff <= rsp_dest_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_new_ff  <= rsp_new_in;
   end

   assign busy            = busy_ff;
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_destination = rsp_dest_ff;
   assign rsp_flow_number = rsp_num_ff;
   assign rsp_new_flow    = rsp_new_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      flow_count_ff <= COUNT_W'(MAX_FLOWS))
      else $error("flow count above table size");

   a_new_is_flow: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_new_ff) |-> (rsp_dest_ff == tfc_pkg::DEST_FLOW))
      else $error("new flow flagged on a non-flow result");

   a_flow_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && is_flow) |=> (busy_ff && !rsp_strobe_ff))
      else $error("flow request did not hold busy");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (flow_count_ff != $past(flow_count_ff)) |-> (rsp_strobe_ff && rsp_new_ff))
      else $error("count moved without a new flow result");

endmodule
